[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: expression does not hold");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/ipv4p_pkg.sv]
package ipv4p_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LINE_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OCTET_MAX   = 255;
  localparam int unsigned OCTET_COUNT = 4;
  localparam int unsigned OCTET_BITS  = 8;
  localparam int unsigned PART_SAT    = 256;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'd46;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_NEWLINE,
    CLS_TAB,
    CLS_DOT,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        eos;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_t           status;
    logic [LINE_W-1:0] line_number;
  } result_t;

endpackage

[rtl/core/ipv4p_fifo.sv]
module ipv4p_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ipv4p_pkg::MID_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/core/ipv4p_front.sv]
module ipv4p_front (
  input  logic                          in_push,
  input  logic [ipv4p_pkg::CHAR_W-1:0]  in_char_byte,
  input  logic                          in_end_of_stream,
  output logic                          item_push,
  output ipv4p_pkg::item_t              item
);

  logic [ipv4p_pkg::CHAR_W-1:0] offset;

  assign item_push = in_push;
  assign offset    = in_char_byte - ipv4p_pkg::CH_ZERO;

  always_comb begin
    item.eos   = in_end_of_stream;
    item.digit = offset[3:0];
    if (in_char_byte >= ipv4p_pkg::CH_ZERO && in_char_byte <= ipv4p_pkg::CH_NINE) begin
      item.cls = ipv4p_pkg::CLS_DIGIT;
    end else begin
      unique case (in_char_byte)
        ipv4p_pkg::CH_NEWLINE: item.cls = ipv4p_pkg::CLS_NEWLINE;
        ipv4p_pkg::CH_TAB:     item.cls = ipv4p_pkg::CLS_TAB;
        ipv4p_pkg::CH_DOT:     item.cls = ipv4p_pkg::CLS_DOT;
        ipv4p_pkg::CH_MINUS:   item.cls = ipv4p_pkg::CLS_MINUS;
        default:               item.cls = ipv4p_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

[rtl/core/ipv4p_back.sv]
`include "assert_macros.svh"

module ipv4p_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  ipv4p_pkg::item_t    item,
  output logic                item_take,
  input  logic                res_full,
  output logic                res_push,
  output ipv4p_pkg::result_t  res
);

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_MINUS  = 2'd1,
    MODE_DIGITS = 2'd2,
    MODE_PAST   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                           has_bytes;
    logic                           field_done;
    logic [2:0]                     octets;
    logic [8:0]                     value;
    mode_t                          mode;
    logic                           negative;
    logic [ipv4p_pkg::ADDR_W-1:0]   shift;
    ipv4p_pkg::status_t             status;
  } line_t;

  function automatic line_t clear_part(line_t s);
    s.value    = '0;
    s.mode     = MODE_START;
    s.negative = 1'b0;
    return s;
  endfunction

  function automatic line_t finish_part(line_t s);
    if (s.mode == MODE_START || s.mode == MODE_MINUS || (s.negative && s.value != '0) ||
        s.value > 9'(ipv4p_pkg::OCTET_MAX)) begin
      s.status = ipv4p_pkg::ST_BAD;
    end else begin
      s.shift  = {s.shift[ipv4p_pkg::ADDR_W-ipv4p_pkg::OCTET_BITS-1:0],
                  s.value[ipv4p_pkg::OCTET_BITS-1:0]};
      s.octets = s.octets + 3'd1;
    end
    return clear_part(s);
  endfunction

  function automatic line_t finish_field(line_t s);
    if (s.status == ipv4p_pkg::ST_OK && s.octets < 3'(ipv4p_pkg::OCTET_COUNT)) begin
      s = finish_part(s);
      if (s.status == ipv4p_pkg::ST_OK && s.octets < 3'(ipv4p_pkg::OCTET_COUNT)) begin
        s.status = ipv4p_pkg::ST_SHORT;
      end
    end
    s.field_done = 1'b1;
    return s;
  endfunction

  function automatic line_t stray_char(line_t s);
    if (s.mode == MODE_START || s.mode == MODE_MINUS) begin
      s.status = ipv4p_pkg::ST_BAD;
    end else begin
      s.mode = MODE_PAST;
    end
    return s;
  endfunction

  function automatic line_t field_char(line_t s, ipv4p_pkg::item_t it);
    logic [11:0] acc;
    acc = {3'b0, s.value} * 12'd10 + {8'b0, it.digit};
    if (s.status == ipv4p_pkg::ST_OK && s.octets < 3'(ipv4p_pkg::OCTET_COUNT)) begin
      case (it.cls)
        ipv4p_pkg::CLS_DOT: s = finish_part(s);
        ipv4p_pkg::CLS_DIGIT: begin
          if (s.mode == MODE_START || s.mode == MODE_MINUS) begin
            s.value = {5'b0, it.digit};
            s.mode  = MODE_DIGITS;
          end else if (s.mode == MODE_DIGITS) begin
            s.value = (acc > 12'(ipv4p_pkg::PART_SAT)) ? 9'(ipv4p_pkg::PART_SAT) : acc[8:0];
          end
        end
        ipv4p_pkg::CLS_MINUS: begin
          if (s.mode == MODE_START) begin
            s.mode     = MODE_MINUS;
            s.negative = 1'b1;
          end else begin
            s = stray_char(s);
          end
        end
        default: s = stray_char(s);
      endcase
    end
    return s;
  endfunction

  line_t                          line_r, line_nxt;
  logic [ipv4p_pkg::LINE_W-1:0]   count_r, count_nxt;
  logic                           emit;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take && emit;

  always_comb begin
    line_nxt  = line_r;
    count_nxt = count_r;
    emit      = 1'b0;
    res       = '0;
    if (item.cls != ipv4p_pkg::CLS_NEWLINE) begin
      if (!line_nxt.field_done) begin
        if (item.cls == ipv4p_pkg::CLS_TAB) begin
          if (!line_nxt.has_bytes) begin
            line_nxt.status     = ipv4p_pkg::ST_EMPTY;
            line_nxt.field_done = 1'b1;
          end else begin
            line_nxt = finish_field(line_nxt);
          end
        end else begin
          line_nxt = field_char(line_nxt, item);
        end
      end
      line_nxt.has_bytes = 1'b1;
    end
    if (item.cls == ipv4p_pkg::CLS_NEWLINE || item.eos) begin
      if (count_nxt != '1) begin
        count_nxt = count_nxt + ipv4p_pkg::LINE_W'(1);
      end
      if (line_nxt.has_bytes) begin
        if (!line_nxt.field_done) begin
          line_nxt = finish_field(line_nxt);
        end
        emit            = 1'b1;
        res.address     = (line_nxt.status == ipv4p_pkg::ST_OK) ? line_nxt.shift : '0;
        res.status      = line_nxt.status;
        res.line_number = count_nxt;
      end
      line_nxt = '0;
    end
    if (item.eos) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      count_r <= '0;
    end else if (item_take) begin
      line_r  <= line_nxt;
      count_r <= count_nxt;
    end
  end

  `ASSERT_ALWAYS(a_octets_bounded, clk, rst_n, line_r.octets <= 3'(ipv4p_pkg::OCTET_COUNT))
  `ASSERT_IMPLIES(a_done_has_bytes, clk, rst_n, line_r.field_done, line_r.has_bytes)
  `ASSERT_IMPLIES(a_err_zero_addr, clk, rst_n, res_push && res.status != ipv4p_pkg::ST_OK, res.address == '0)
  `ASSERT_IMPLIES(a_result_numbered, clk, rst_n, res_push, res.line_number != '0)

endmodule

[rtl/core/ipv4_dotted_line_parser_unit.sv]
// Dotted-decimal IPv4 line parser.
// Input queue side: one text byte per request on in_char_byte, with
// in_end_of_stream marking the last byte; a request is taken on a clock edge
// with in_push high and in_full low. Newline or the end-of-stream byte ends
// a line. Each non-empty line yields one request on the result side:
// out_address, out_status and the one-based out_line_number, shown while
// out_empty is low and taken on an edge with out_pop high.
// Throughput: one byte per cycle while the result queue has room, set by the
// parse step in the back end and its one-byte-per-cycle byte queue.
// Path: the line-ending byte is registered in the byte queue, then moves out
// of it, through the parse step and into the result queue, where its result
// is shown; a full result queue holds the byte in the byte queue.
// When the receiver stalls, the result queue fills, the parser stops pulling
// bytes and the byte queue then raises in_full; nothing is dropped.
// Synchronous reset clears both queues, the line counter and the line state.
module ipv4_dotted_line_parser_unit #(
  parameter int unsigned MID_DEPTH = ipv4p_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = ipv4p_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte input queue
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [ipv4p_pkg::CHAR_W-1:0]     in_char_byte,
  input  logic                             in_end_of_stream,
  // result output queue
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [ipv4p_pkg::ADDR_W-1:0]     out_address,
  output logic [ipv4p_pkg::STATUS_W-1:0]   out_status,
  output logic [ipv4p_pkg::LINE_W-1:0]     out_line_number
);

  localparam int unsigned ITEM_W = $bits(ipv4p_pkg::item_t);
  localparam int unsigned RES_W  = $bits(ipv4p_pkg::result_t);

  ipv4p_pkg::item_t   front_item;
  logic               front_push;
  logic [ITEM_W-1:0]  mid_data;
  logic               mid_empty;
  ipv4p_pkg::item_t   back_item;
  logic               back_take;
  ipv4p_pkg::result_t back_res;
  logic               back_push;
  logic               out_full;
  logic [RES_W-1:0]   out_data;
  ipv4p_pkg::result_t out_head;

  // Classify each incoming byte.
  ipv4p_front u_front (
    .in_push          (in_push),
    .in_char_byte     (in_char_byte),
    .in_end_of_stream (in_end_of_stream),
    .item_push        (front_push),
    .item             (front_item)
  );

  // Decouple the front end from the parse step.
  ipv4p_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_item),
    .full      (in_full),
    .pop       (back_take),
    .pop_data  (mid_data),
    .empty     (mid_empty)
  );

  assign back_item = ipv4p_pkg::item_t'(mid_data);

  // Advance the line state one byte per cycle while the result queue has room, and emit finished lines.
  ipv4p_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!mid_empty),
    .item       (back_item),
    .item_take  (back_take),
    .res_full   (out_full),
    .res_push   (back_push),
    .res        (back_res)
  );

  // Hold results until the receiver pops them.
  ipv4p_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (back_push),
    .push_data (back_res),
    .full      (out_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  assign out_head        = ipv4p_pkg::result_t'(out_data);
  assign out_address     = out_head.address;
  assign out_status      = out_head.status;
  assign out_line_number = out_head.line_number;

endmodule

[bench/tb_ipv4_dotted_line_parser_unit.sv]
`timescale 1ns / 1ps

module tb_ipv4_dotted_line_parser_unit;

  // Random byte budget, drain allowance and watchdog limit in clock cycles.
  localparam int unsigned RANDOM_BYTES = 1650;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef bit [ipv4p_pkg::CHAR_W-1:0] text_q_t[$];

  // Line scoreboard: tracks the parse state of the current line, queues the
  // expected result of each non-empty line and compares results as they pop.
  class ipv4_line_scoreboard;
    typedef enum {PM_START, PM_MINUS, PM_DIGITS, PM_PAST} part_mode_t;

    bit [ipv4p_pkg::LINE_W-1:0] line_count;
    bit                         line_has_bytes;
    bit                         field_done;
    int unsigned                octets_done;
    bit [8:0]                   part_value;
    part_mode_t                 part_mode;
    bit                         part_negative;
    bit [ipv4p_pkg::ADDR_W-1:0] address_shift;
    ipv4p_pkg::status_t         line_status;
    ipv4p_pkg::result_t         expected_lines[$];
    int unsigned                fail_count;

    function new();
      line_count = '0;
      fail_count = 0;
      clear_line();
    endfunction

    function void clear_part();
      part_value    = '0;
      part_mode     = PM_START;
      part_negative = 1'b0;
    endfunction

    function void clear_line();
      line_has_bytes = 1'b0;
      field_done     = 1'b0;
      octets_done    = 0;
      address_shift  = '0;
      line_status    = ipv4p_pkg::ST_OK;
      clear_part();
    endfunction

    // Close a part at a dot or at the end of the field.
    function void close_part();
      if (part_mode == PM_START || part_mode == PM_MINUS ||
          (part_negative && part_value != 0) || part_value > ipv4p_pkg::OCTET_MAX) begin
        line_status = ipv4p_pkg::ST_BAD;
      end else begin
        address_shift = {address_shift[ipv4p_pkg::ADDR_W-ipv4p_pkg::OCTET_BITS-1:0],
                         part_value[7:0]};
        octets_done++;
      end
      clear_part();
    endfunction

    function void close_field();
      if (line_status == ipv4p_pkg::ST_OK && octets_done < ipv4p_pkg::OCTET_COUNT) begin
        close_part();
        if (line_status == ipv4p_pkg::ST_OK && octets_done < ipv4p_pkg::OCTET_COUNT)
          line_status = ipv4p_pkg::ST_SHORT;
      end
      field_done = 1'b1;
    endfunction

    function void field_char(bit [ipv4p_pkg::CHAR_W-1:0] c);
      int unsigned v;
      if (line_status != ipv4p_pkg::ST_OK || octets_done >= ipv4p_pkg::OCTET_COUNT) return;
      if (c == ipv4p_pkg::CH_DOT) begin
        close_part();
      end else if (c >= ipv4p_pkg::CH_ZERO && c <= ipv4p_pkg::CH_NINE) begin
        if (part_mode == PM_START || part_mode == PM_MINUS) begin
          part_value = 9'(c - ipv4p_pkg::CH_ZERO);
          part_mode  = PM_DIGITS;
        end else if (part_mode == PM_DIGITS) begin
          v = part_value * 10 + (c - ipv4p_pkg::CH_ZERO);
          part_value = 9'((v > ipv4p_pkg::PART_SAT) ? ipv4p_pkg::PART_SAT : v);
        end
      end else if (c == ipv4p_pkg::CH_MINUS && part_mode == PM_START) begin
        part_mode     = PM_MINUS;
        part_negative = 1'b1;
      end else begin
        if (part_mode == PM_START || part_mode == PM_MINUS) line_status = ipv4p_pkg::ST_BAD;
        else part_mode = PM_PAST;
      end
    endfunction

    function void end_line();
      ipv4p_pkg::result_t r;
      if (line_count != '1) line_count++;
      if (line_has_bytes) begin
        if (!field_done) close_field();
        r.address     = (line_status == ipv4p_pkg::ST_OK) ? address_shift : '0;
        r.status      = line_status;
        r.line_number = line_count;
        expected_lines.insert(expected_lines.size(), r);
      end
      clear_line();
    endfunction

    // Advance the line state by one accepted byte request.
    function void note_byte(bit [ipv4p_pkg::CHAR_W-1:0] c, bit eos);
      if (c == ipv4p_pkg::CH_NEWLINE) begin
        end_line();
      end else begin
        if (!field_done) begin
          if (c == ipv4p_pkg::CH_TAB) begin
            if (!line_has_bytes) begin
              line_status = ipv4p_pkg::ST_EMPTY;
              field_done  = 1'b1;
            end else begin
              close_field();
            end
          end else begin
            field_char(c);
          end
        end
        line_has_bytes = 1'b1;
        if (eos) end_line();
      end
      // The byte after an end-of-stream mark starts a new stream.
      if (eos) line_count = '0;
    endfunction

    // Compare one popped result with the oldest expected line.
    function void check_line(logic [ipv4p_pkg::ADDR_W-1:0] address,
                             logic [ipv4p_pkg::STATUS_W-1:0] status,
                             logic [ipv4p_pkg::LINE_W-1:0] line_number);
      ipv4p_pkg::result_t r;
      if (expected_lines.size() == 0) begin
        $error("result with no line pending: address %h, status %0d, line_number %0d",
               address, status, line_number);
        fail_count++;
        return;
      end
      r = expected_lines.pop_front();
      if (address !== r.address) begin
        $error("address mismatch: expected %h, actual %h", r.address, address);
        fail_count++;
      end
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, status);
        fail_count++;
      end
      if (line_number !== r.line_number) begin
        $error("line_number mismatch: expected %0d, actual %0d", r.line_number, line_number);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_push;
  logic                           in_full;
  logic [ipv4p_pkg::CHAR_W-1:0]   in_char_byte;
  logic                           in_end_of_stream;
  logic                           out_empty;
  logic                           out_pop;
  logic [ipv4p_pkg::ADDR_W-1:0]   out_address;
  logic [ipv4p_pkg::STATUS_W-1:0] out_status;
  logic [ipv4p_pkg::LINE_W-1:0]   out_line_number;

  ipv4_line_scoreboard sb = new();
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         cycle_count = 0;

  ipv4_dotted_line_parser_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char_byte     (in_char_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_address      (out_address),
    .out_status       (out_status),
    .out_line_number  (out_line_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: give up when the run goes far past any correct schedule.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Sample both handshakes on the pre-edge values, then pick the next pop.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_byte(in_char_byte, in_end_of_stream);
      if (out_pop && !out_empty) sb.check_line(out_address, out_status, out_line_number);
    end
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Push one byte request; idle first at the sender's rate, then hold the
  // request until a clock edge sees in_full low.
  task automatic push_byte(input bit [ipv4p_pkg::CHAR_W-1:0] c, input bit eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_char_byte     <= c;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Push a run of bytes, marking the last one as end of stream when asked.
  task automatic push_text(input text_q_t q, input bit eos_last);
    for (int i = 0; i < q.size(); i++) push_byte(q[i], eos_last && (i == q.size() - 1));
  endtask

  // Append one byte at the tail of a text run.
  function automatic void add_byte(ref text_q_t q, input bit [ipv4p_pkg::CHAR_W-1:0] b);
    q.insert(q.size(), b);
  endfunction

  task automatic push_string(input string s, input bit eos_last);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) add_byte(q, s[i]);
    push_text(q, eos_last);
  endtask

  function automatic void add_number(ref text_q_t q, input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) add_byte(q, s[i]);
  endfunction

  // Append one octet part; defect picks the flaw to inject (0 for none).
  function automatic void add_octet(ref text_q_t q, input int unsigned defect);
    int unsigned r;
    r = $urandom_range(9);
    case (defect)
      1: add_number(q, $urandom_range(999, 256));
      2: add_number(q, $urandom_range(99999, 1000));
      3: ;
      4: begin
        add_byte(q, 8'("a" + $urandom_range(25)));
        add_number(q, $urandom_range(255));
      end
      5: begin
        add_byte(q, ipv4p_pkg::CH_MINUS);
        add_number(q, $urandom_range(255, 1));
      end
      6: add_byte(q, ipv4p_pkg::CH_MINUS);
      default: begin
        if ($urandom_range(15) == 0) begin
          add_byte(q, ipv4p_pkg::CH_MINUS);
          add_byte(q, ipv4p_pkg::CH_ZERO);
        end else begin
          if ($urandom_range(7) == 0) add_byte(q, ipv4p_pkg::CH_ZERO);
          add_number(q, (r == 0) ? 0 : (r == 1) ? ipv4p_pkg::OCTET_MAX : $urandom_range(255));
        end
        // Trailing junk after the digits is skipped.
        if ($urandom_range(9) == 0) add_byte(q, 8'("a" + $urandom_range(25)));
        if ($urandom_range(19) == 0) add_byte(q, ipv4p_pkg::CH_MINUS);
      end
    endcase
  endfunction

  // Build one random line: mostly well-formed addresses with random content,
  // then broken addresses, raw noise, empty lines and tab-first lines.
  function automatic void build_line(ref text_q_t q, ref bit eos_last);
    int unsigned kind;
    int unsigned flaw_at;
    int unsigned flaw;
    int unsigned n;
    kind     = $urandom_range(99);
    eos_last = 1'b0;
    if (kind < 80) begin
      flaw_at = (kind < 60) ? 4 : $urandom_range(3);
      flaw    = $urandom_range(8, 1);
      n       = (kind >= 60 && flaw == 7) ? flaw_at + 1 : 4;
      for (int i = 0; i < n; i++) begin
        if (i > 0) add_byte(q, ipv4p_pkg::CH_DOT);
        add_octet(q, (i == flaw_at && flaw <= 6) ? flaw : 0);
      end
      // Trailing dot leaves an empty last part.
      if (kind >= 60 && flaw == 8) add_byte(q, ipv4p_pkg::CH_DOT);
      case ($urandom_range(3))
        0: begin
          add_byte(q, ipv4p_pkg::CH_TAB);
          repeat ($urandom_range(6)) add_byte(q, 8'($urandom_range(255, 11)));
        end
        1: begin
          add_byte(q, ipv4p_pkg::CH_DOT);
          add_number(q, $urandom_range(999));
        end
        default: ;
      endcase
    end else if (kind < 92) begin
      repeat ($urandom_range(12, 1)) add_byte(q, 8'($urandom_range(255)));
    end else if (kind < 96) begin
      ;
    end else begin
      add_byte(q, ipv4p_pkg::CH_TAB);
      repeat ($urandom_range(4)) add_byte(q, 8'($urandom_range(255, 11)));
    end
    case ($urandom_range(19))
      0: begin
        if (q.size() == 0) add_byte(q, ipv4p_pkg::CH_NEWLINE);
        eos_last = 1'b1;
      end
      1: begin
        add_byte(q, ipv4p_pkg::CH_NEWLINE);
        eos_last = 1'b1;
      end
      default: add_byte(q, ipv4p_pkg::CH_NEWLINE);
    endcase
  endfunction

  initial begin
    text_q_t     line;
    bit          eos_last;
    int unsigned sent;
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_char_byte     = '0;
    in_end_of_stream = 1'b0;
    out_pop          = 1'b0;
    send_idle_pct    = 13;
    recv_idle_pct    = 69;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: empty line, tab first, extremes of the octets with
    // minus zero and junk after the fourth octet, overflow, short address,
    // trailing dot, negative octet, bytes zero and 255, and end of stream
    // on both a plain byte and a newline.
    push_string("\n", 1'b0);
    push_string("\tz\n", 1'b0);
    push_string("255.0.-0.7x.9\n", 1'b0);
    push_string("256.1\n", 1'b0);
    push_string("1.2.3\n", 1'b0);
    push_string("1.2.3.\n", 1'b0);
    push_string("-1.2.3.4\n", 1'b0);
    push_text('{8'd0, 8'd255, ipv4p_pkg::CH_NEWLINE}, 1'b0);
    push_string("a.1.1.1\tq", 1'b1);
    push_string("9.9.9.9\n", 1'b1);
    push_string("1.2.3.4\n", 1'b0);

    // Random lines in three idling phases: receiver-bound, sender-bound, none.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= RANDOM_BYTES / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 13;
      end
      line.delete();
      build_line(line, eos_last);
      push_text(line, eos_last);
      sent += line.size();
    end
    in_push <= 1'b0;

    // Drain: wait for every pending line, then wait the drain allowance for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
